/* rtl/core/cpu_mcycle_load_incdec_exec_core_macros.svh */
// Assertion helpers for the port-level checker.
`ifndef CPU_MCYCLE_LOAD_INCDEC_EXEC_CORE_MACROS_SVH
`define CPU_MCYCLE_LOAD_INCDEC_EXEC_CORE_MACROS_SVH
// Implication checked on every rising clock edge, off while reset is low.
`define CMX_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, off while reset is low.
`define CMX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/cmx_pkg.sv */
// ----------------------------------------------------------------------------
// cmx_pkg
// Shared constants for the machine-cycle CPU core.
// ----------------------------------------------------------------------------
package cmx_pkg;
    localparam logic [7:0] FLAG_Z = 8'h80;
    localparam logic [7:0] FLAG_N = 8'h40;
    localparam logic [7:0] FLAG_H = 8'h20;
    localparam logic [7:0] FLAG_C = 8'h10;
    localparam logic [2:0] SLOT_MEM = 3'd6;
    localparam logic [2:0] SLOT_A   = 3'd7;
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_LDSP  = 8'h08;
    localparam logic [7:0] OP_RLCA  = 8'h07;
    localparam logic [7:0] OP_RRCA  = 8'h0F;

    function automatic logic op_valid(input logic [7:0] op);
        logic [2:0] lo;
        lo = op[2:0];
        if (op[7:6] != 2'b00) return 1'b0;
        if (lo >= 3'd1 && lo <= 3'd6) return 1'b1;
        return (op == OP_NOP) || (op == OP_LDSP) || (op == OP_RLCA) || (op == OP_RRCA);
    endfunction

    function automatic logic [2:0] op_length(input logic [7:0] op);
        logic [2:0] lo;
        logic [2:0] r;
        lo = op[2:0];
        r  = op[5:3];
        if (!op_valid(op)) return 3'd1;
        unique case (lo)
            3'd0: return (op == OP_LDSP) ? 3'd5 : 3'd1;
            3'd1: return op[3] ? 3'd2 : 3'd3;
            3'd2, 3'd3: return 3'd2;
            3'd4, 3'd5: return (r == SLOT_MEM) ? 3'd3 : 3'd1;
            3'd6: return (r == SLOT_MEM) ? 3'd3 : 3'd2;
            default: return 3'd1;
        endcase
    endfunction
endpackage

/* rtl/core/cpu_mcycle_load_incdec_exec_core.sv */
// ----------------------------------------------------------------------------
// cpu_mcycle_load_incdec_exec_core
// One machine cycle of an 8-bit CPU core per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries the byte returned for the bus access the
// previous result announced; the block finishes that machine cycle and
// returns the next access plus the register file. The architectural state
// and the result register update together on the accepting edge, and a new
// transaction is taken every clock as long as the result register is empty
// or being drained in the same cycle. After reset the pending access is an
// opcode read at address 0. Once an opcode outside the supported set is
// fetched, o_stopped rises and the core holds all state and announces idle
// reads of address 0 until reset.
module cpu_mcycle_load_incdec_exec_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_read_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_bus_address,
    output logic        o_bus_we,
    output logic [7:0]  o_bus_wdata,
    output logic [7:0]  o_acc_value,
    output logic [7:0]  o_flag_value,
    output logic [15:0] o_pair_bc,
    output logic [15:0] o_pair_de,
    output logic [15:0] o_pair_hl,
    output logic [15:0] o_stack_ptr,
    output logic [15:0] o_prog_counter,
    output logic        o_stopped
);
    import cmx_pkg::*;

    // Architectural state
    logic [7:0]  r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [15:0] r_sp, r_pc, r_scr;
    logic [7:0]  r_op;
    logic [2:0]  r_cyc;
    logic        r_stop;
    logic [7:0]  n_a, n_f, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [15:0] n_sp, n_pc, n_scr;
    logic [7:0]  n_op;
    logic [2:0]  n_cyc;
    logic        n_stop;

    // Result register
    logic        r_ovalid;
    logic [15:0] r_addr;
    logic        r_wr;
    logic [7:0]  r_wd;
    logic [15:0] n_addr;
    logic        n_wr;
    logic [7:0]  n_wd;

    logic accept;
    assign o_ready = !r_ovalid || i_ready;
    assign accept  = i_valid && o_ready;

    // Execute stage: finish the current machine cycle.
    always_comb begin
        logic [2:0]  lo, r;
        logic [1:0]  p;
        logic        last, dec;
        logic [15:0] hl, v, pv;
        logic [16:0] sum;
        logic [12:0] hsum;
        logic [7:0]  tgt, res, fl;
        logic [7:0]  d;
        d   = i_read_data;
        lo  = r_op[2:0];
        r   = r_op[5:3];
        p   = r_op[5:4];
        last = (r_cyc + 3'd1 >= op_length(r_op)) || (r_cyc == 3'd7);
        dec = (lo == 3'd5);
        n_a = r_a; n_f = r_f; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        n_h = r_h; n_l = r_l; n_sp = r_sp; n_pc = r_pc; n_scr = r_scr;
        n_op = r_op; n_cyc = r_cyc; n_stop = r_stop;
        hl = {r_h, r_l};
        unique case (p)
            2'd0: pv = {r_b, r_c};
            2'd1: pv = {r_d, r_e};
            2'd2: pv = {r_h, r_l};
            default: pv = r_sp;
        endcase
        v = pv;
        sum  = {1'b0, hl} + {1'b0, v};
        hsum = {1'b0, hl[11:0]} + {1'b0, v[11:0]};
        unique case (r)
            3'd0: tgt = r_b;
            3'd1: tgt = r_c;
            3'd2: tgt = r_d;
            3'd3: tgt = r_e;
            3'd4: tgt = r_h;
            3'd5: tgt = r_l;
            3'd6: tgt = r_scr[7:0];
            default: tgt = r_a;
        endcase
        res = dec ? tgt - 8'd1 : tgt + 8'd1;
        if (r == SLOT_MEM) res = r_scr[7:0];
        fl = r_f & FLAG_C;
        if (res == 8'd0) fl = fl | FLAG_Z;
        if (dec) begin
            fl = fl | FLAG_N;
            if (res[3:0] == 4'hF) fl = fl | FLAG_H;
        end else if (res[3:0] == 4'h0) begin
            fl = fl | FLAG_H;
        end

        unique case (lo)
            3'd0: begin
                if (r_op == OP_LDSP) begin
                    if (r_cyc == 3'd0) begin
                        n_scr = {8'd0, d}; n_pc = r_pc + 16'd1;
                    end else if (r_cyc == 3'd1) begin
                        n_scr = r_scr + {d, 8'd0}; n_pc = r_pc + 16'd1;
                    end else if (r_cyc == 3'd2) begin
                        n_scr = r_scr + 16'd1;
                    end
                end
            end
            3'd1: begin
                if (r_op[3]) begin
                    if (r_cyc == 3'd1) begin
                        n_f = (r_f & FLAG_Z) | (hsum[12] ? FLAG_H : 8'd0)
                            | (sum[16] ? FLAG_C : 8'd0);
                        {n_h, n_l} = sum[15:0];
                    end
                end else if (r_cyc == 3'd0) begin
                    unique case (p)
                        2'd0: n_c = d;
                        2'd1: n_e = d;
                        2'd2: n_l = d;
                        default: n_sp = {8'd0, d};
                    endcase
                    n_pc = r_pc + 16'd1;
                end else if (r_cyc == 3'd1) begin
                    unique case (p)
                        2'd0: n_b = d;
                        2'd1: n_d = d;
                        2'd2: n_h = d;
                        default: n_sp = r_sp + {d, 8'd0};
                    endcase
                    n_pc = r_pc + 16'd1;
                end
            end
            3'd2: begin
                if (r_cyc == 3'd0) begin
                    if (r_op[3]) n_a = d;
                    if (p == 2'd2) {n_h, n_l} = hl + 16'd1;
                    else if (p == 2'd3) {n_h, n_l} = hl - 16'd1;
                end
            end
            3'd3: begin
                if (r_cyc == 3'd0) begin
                    unique case (p)
                        2'd0: {n_b, n_c} = r_op[3] ? pv - 16'd1 : pv + 16'd1;
                        2'd1: {n_d, n_e} = r_op[3] ? pv - 16'd1 : pv + 16'd1;
                        2'd2: {n_h, n_l} = r_op[3] ? pv - 16'd1 : pv + 16'd1;
                        default: n_sp = r_op[3] ? pv - 16'd1 : pv + 16'd1;
                    endcase
                end
            end
            3'd4, 3'd5: begin
                if (r == SLOT_MEM) begin
                    if (r_cyc == 3'd0) n_scr = {8'd0, dec ? d - 8'd1 : d + 8'd1};
                    else if (r_cyc == 3'd1) n_f = fl;
                end else if (r_cyc == 3'd0) begin
                    n_f = fl;
                    unique case (r)
                        3'd0: n_b = res;
                        3'd1: n_c = res;
                        3'd2: n_d = res;
                        3'd3: n_e = res;
                        3'd4: n_h = res;
                        3'd5: n_l = res;
                        default: n_a = res;
                    endcase
                end
            end
            3'd6: begin
                if (r_cyc == 3'd0) begin
                    n_scr = {8'd0, d}; n_pc = r_pc + 16'd1;
                end else if (r_cyc == 3'd1 && r != SLOT_MEM) begin
                    unique case (r)
                        3'd0: n_b = r_scr[7:0];
                        3'd1: n_c = r_scr[7:0];
                        3'd2: n_d = r_scr[7:0];
                        3'd3: n_e = r_scr[7:0];
                        3'd4: n_h = r_scr[7:0];
                        3'd5: n_l = r_scr[7:0];
                        default: n_a = r_scr[7:0];
                    endcase
                end
            end
            default: begin
                if (r_cyc == 3'd0) begin
                    if (r_op == OP_RLCA) begin
                        n_a = {r_a[6:0], r_a[7]};
                        n_f = r_a[7] ? FLAG_C : 8'd0;
                    end else begin
                        n_a = {r_a[0], r_a[7:1]};
                        n_f = r_a[0] ? FLAG_C : 8'd0;
                    end
                end
            end
        endcase

        if (last) begin
            n_op  = d;
            n_pc  = n_pc + 16'd1;
            n_cyc = 3'd0;
            if (!op_valid(d)) n_stop = 1'b1;
        end else begin
            n_cyc = r_cyc + 3'd1;
        end

        if (r_stop) begin
            n_a = r_a; n_f = r_f; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
            n_h = r_h; n_l = r_l; n_sp = r_sp; n_pc = r_pc; n_scr = r_scr;
            n_op = r_op; n_cyc = r_cyc; n_stop = r_stop;
        end
    end

    // Next bus access, from the updated state.
    always_comb begin
        logic [2:0] lo, r;
        logic [1:0] p;
        lo = n_op[2:0];
        r  = n_op[5:3];
        p  = n_op[5:4];
        n_addr = 16'd0; n_wr = 1'b0; n_wd = 8'd0;
        if (n_stop) begin
            n_addr = 16'd0;
        end else if (n_cyc + 3'd1 >= op_length(n_op) || n_cyc == 3'd7) begin
            n_addr = n_pc;
        end else begin
            unique case (lo)
                3'd0: begin
                    if (n_cyc <= 3'd1) begin
                        n_addr = n_pc;
                    end else begin
                        n_addr = n_scr; n_wr = 1'b1;
                        n_wd = (n_cyc == 3'd2) ? n_sp[7:0] : n_sp[15:8];
                    end
                end
                3'd1: if (!n_op[3]) n_addr = n_pc;
                3'd2: begin
                    unique case (p)
                        2'd0: n_addr = {n_b, n_c};
                        2'd1: n_addr = {n_d, n_e};
                        default: n_addr = {n_h, n_l};
                    endcase
                    if (!n_op[3]) begin
                        n_wr = 1'b1; n_wd = n_a;
                    end
                end
                3'd4, 3'd5, 3'd6: begin
                    if (lo == 3'd6 && n_cyc == 3'd0) begin
                        n_addr = n_pc;
                    end else if (r == SLOT_MEM) begin
                        n_addr = {n_h, n_l};
                        if (n_cyc >= 3'd1) begin
                            n_wr = 1'b1; n_wd = n_scr[7:0];
                        end
                    end
                end
                default: n_addr = 16'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0; r_f <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0;
            r_h <= '0; r_l <= '0; r_sp <= '0; r_pc <= '0; r_scr <= '0;
            r_op <= OP_NOP; r_cyc <= '0; r_stop <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_a <= n_a; r_f <= n_f; r_b <= n_b; r_c <= n_c; r_d <= n_d;
                r_e <= n_e; r_h <= n_h; r_l <= n_l; r_sp <= n_sp; r_pc <= n_pc;
                r_scr <= n_scr; r_op <= n_op; r_cyc <= n_cyc; r_stop <= n_stop;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= n_addr; r_wr <= n_wr; r_wd <= n_wd;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_bus_address    = r_addr;
    assign o_bus_we         = r_wr;
    assign o_bus_wdata      = r_wd;
    assign o_acc_value      = r_a;
    assign o_flag_value     = {r_f[7:4], 4'd0};
    assign o_pair_bc        = {r_b, r_c};
    assign o_pair_de        = {r_d, r_e};
    assign o_pair_hl        = {r_h, r_l};
    assign o_stack_ptr      = r_sp;
    assign o_prog_counter   = r_pc;
    assign o_stopped        = r_stop;
endmodule

/* rtl/core/cmx_checker.sv */
// ----------------------------------------------------------------------------
// cmx_checker
// Port-level checks for the machine-cycle CPU core.
// ----------------------------------------------------------------------------
`include "cpu_mcycle_load_incdec_exec_core_macros.svh"
module cmx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_bus_address,
    input logic        o_bus_we,
    input logic [7:0]  o_bus_wdata,
    input logic [7:0]  o_flag_value,
    input logic        o_stopped
);
    `CMX_ASSERT_IMPL(a_wdata_zero, o_valid && !o_bus_we, o_bus_wdata == 8'd0)
    `CMX_ASSERT_IMPL(a_flag_low, o_valid, o_flag_value[3:0] == 4'd0)
    `CMX_ASSERT_IMPL(a_stop_idle, o_valid && o_stopped, o_bus_address == 16'd0 && !o_bus_we)
    `CMX_ASSERT_NEXT(a_stop_sticky, o_stopped, o_stopped)
    `CMX_ASSERT_IMPL(a_ready_free, !o_valid, o_ready)
endmodule

bind cpu_mcycle_load_incdec_exec_core cmx_checker u_cmx_checker (.*);

/* verif/cpu_mcycle_load_incdec_exec_core_tb.sv */
// ----------------------------------------------------------------------------
// cpu_mcycle_load_incdec_exec_core_tb
// Self-checking bench for the machine-cycle CPU core.
// ----------------------------------------------------------------------------
// The bench plays the part of memory. Each transaction it sends is the byte
// for the access the core announced last. A cycle-accurate shadow of the core
// runs while the stimulus is built, so opcode fetches receive supported
// opcodes and other reads get alternating all-ones and all-zeros bytes in
// the directed program, then random data. Each transaction carries the result
// the shadow expects; it joins the expected-result queue when the core accepts
// it. The run ends with one unsupported opcode and a few stopped transactions.
// ----------------------------------------------------------------------------
module cpu_mcycle_load_incdec_exec_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cmx_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int PAUSE_AT     = 900;   // sender drains the core once here
    localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction on either side

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wdata;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [15:0] pc;
        logic        stop;
    } t_cycle_result;

    typedef struct {
        logic [7:0]    data;
        t_cycle_result want;
    } t_mem_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_read_data = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_bus_address;
    logic        o_bus_we;
    logic [7:0]  o_bus_wdata;
    logic [7:0]  o_acc_value;
    logic [7:0]  o_flag_value;
    logic [15:0] o_pair_bc;
    logic [15:0] o_pair_de;
    logic [15:0] o_pair_hl;
    logic [15:0] o_stack_ptr;
    logic [15:0] o_prog_counter;
    logic        o_stopped;

    cpu_mcycle_load_incdec_exec_core i_dut (.*);

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow core state
    // ------------------------------------------------------------------
    logic [7:0]  sh_a = '0;
    logic [7:0]  sh_f = '0;
    logic [7:0]  sh_gpr [6] = '{default: 8'h00};
    logic [15:0] sh_sp = '0;
    logic [15:0] sh_pc = '0;
    logic [7:0]  sh_op = '0;          // zero behaves as NOP after reset
    logic [2:0]  sh_cyc = '0;
    logic [15:0] sh_tmp = '0;
    logic        sh_halt = 1'b0;

    t_mem_reply    reply_q [$];       // stimulus not yet sent
    t_cycle_result cycle_exp_q [$];   // results owed by the core
    t_mem_reply    cur_reply;
    int            total_items = 0;
    int            sent_cnt = 0;
    int            errors = 0;
    int            burst_left = 1;
    int            gap_left = 0;
    bit            pause_done = 1'b0;
    int            run_left = 0;
    int            stall_left = 0;
    int            idle_cnt = 0;

    function automatic bit op_supported(input logic [7:0] op);
        if (op[7:6] != 2'b00) return 1'b0;
        if (op[2:0] >= 3'd1 && op[2:0] <= 3'd6) return 1'b1;
        return op == OP_NOP || op == OP_LDSP || op == OP_RLCA || op == OP_RRCA;
    endfunction

    function automatic int op_cycles(input logic [7:0] op);
        if (!op_supported(op)) return 1;
        case (op[2:0])
            3'd0: return (op == OP_LDSP) ? 5 : 1;
            3'd1: return op[3] ? 2 : 3;
            3'd2, 3'd3: return 2;
            3'd4, 3'd5: return (op[5:3] == SLOT_MEM) ? 3 : 1;
            3'd6: return (op[5:3] == SLOT_MEM) ? 3 : 2;
            default: return 1;
        endcase
    endfunction

    function logic [15:0] pair_rd(input int k);
        case (k)
            0: return {sh_gpr[0], sh_gpr[1]};
            1: return {sh_gpr[2], sh_gpr[3]};
            2: return {sh_gpr[4], sh_gpr[5]};
            default: return sh_sp;
        endcase
    endfunction

    task pair_wr(input int k, input logic [15:0] v);
        if (k == 3) begin
            sh_sp = v;
        end else begin
            sh_gpr[k * 2]     = v[15:8];
            sh_gpr[k * 2 + 1] = v[7:0];
        end
    endtask

    // INC/DEC r: carry kept, Z/N/H from the 8-bit result
    task incdec_flags(input logic [7:0] res, input bit dec);
        logic [7:0] f;
        f = sh_f & FLAG_C;
        if (res == 8'h00) f |= FLAG_Z;
        if (dec) begin
            f |= FLAG_N;
            if (res[3:0] == 4'hF) f |= FLAG_H;
        end else if (res[3:0] == 4'h0) begin
            f |= FLAG_H;
        end
        sh_f = f;
    endtask

    // Finish the current machine cycle with byte d from the bus.
    task exec_cycle(input logic [7:0] d);
        logic [2:0]  lo;
        logic [2:0]  r;
        int          p;
        int          c;
        bit          last;
        logic [16:0] sum;
        logic [15:0] hl;
        logic [15:0] rr;
        logic [7:0]  f;
        logic [7:0]  t;
        lo   = sh_op[2:0];
        r    = sh_op[5:3];
        p    = sh_op[5:4];
        c    = sh_cyc;
        last = c + 1 >= op_cycles(sh_op);
        case (lo)
            3'd0: begin
                if (sh_op == OP_LDSP) begin
                    if (c == 0) begin
                        sh_tmp = {8'h00, d};
                        sh_pc++;
                    end else if (c == 1) begin
                        sh_tmp = sh_tmp + {d, 8'h00};
                        sh_pc++;
                    end else if (c == 2) begin
                        sh_tmp++;
                    end
                end
            end
            3'd1: begin
                if (sh_op[3]) begin
                    if (c == 1) begin
                        // ADD HL,rr: Z kept, H from bit 11, C from bit 15
                        hl  = pair_rd(2);
                        rr  = pair_rd(p);
                        sum = {1'b0, hl} + {1'b0, rr};
                        f   = sh_f & FLAG_Z;
                        if ({1'b0, hl[11:0]} + {1'b0, rr[11:0]} > 13'hFFF) f |= FLAG_H;
                        if (sum[16]) f |= FLAG_C;
                        sh_f = f;
                        pair_wr(2, sum[15:0]);
                    end
                end else if (c == 0) begin
                    if (p == 3) sh_sp = {8'h00, d};
                    else sh_gpr[p * 2 + 1] = d;
                    sh_pc++;
                end else if (c == 1) begin
                    if (p == 3) sh_sp = sh_sp + {d, 8'h00};
                    else sh_gpr[p * 2] = d;
                    sh_pc++;
                end
            end
            3'd2: begin
                if (c == 0) begin
                    if (sh_op[3]) sh_a = d;
                    if (p == 2) pair_wr(2, pair_rd(2) + 16'd1);
                    else if (p == 3) pair_wr(2, pair_rd(2) - 16'd1);
                end
            end
            3'd3: begin
                if (c == 0) pair_wr(p, sh_op[3] ? pair_rd(p) - 16'd1 : pair_rd(p) + 16'd1);
            end
            3'd4, 3'd5: begin
                if (r == SLOT_MEM) begin
                    if (c == 0) sh_tmp = {8'h00, (lo == 3'd5) ? d - 8'd1 : d + 8'd1};
                    else if (c == 1) incdec_flags(sh_tmp[7:0], lo == 3'd5);
                end else if (c == 0) begin
                    t = (r == SLOT_A) ? sh_a : sh_gpr[r];
                    t = (lo == 3'd5) ? t - 8'd1 : t + 8'd1;
                    if (r == SLOT_A) sh_a = t;
                    else sh_gpr[r] = t;
                    incdec_flags(t, lo == 3'd5);
                end
            end
            3'd6: begin
                if (c == 0) begin
                    sh_tmp = {8'h00, d};
                    sh_pc++;
                end else if (c == 1 && r != SLOT_MEM) begin
                    if (r == SLOT_A) sh_a = sh_tmp[7:0];
                    else sh_gpr[r] = sh_tmp[7:0];
                end
            end
            default: begin
                if (c == 0) begin
                    if (sh_op == OP_RLCA) begin
                        sh_f = sh_a[7] ? FLAG_C : 8'h00;
                        sh_a = {sh_a[6:0], sh_a[7]};
                    end else begin
                        sh_f = sh_a[0] ? FLAG_C : 8'h00;
                        sh_a = {sh_a[0], sh_a[7:1]};
                    end
                end
            end
        endcase
        // Last cycle of each instruction doubles as the next opcode fetch.
        if (last) begin
            sh_op  = d;
            sh_pc++;
            sh_cyc = '0;
            if (!op_supported(d)) sh_halt = 1'b1;
        end else begin
            sh_cyc++;
        end
    endtask

    // Next bus access plus the register file after this cycle.
    function t_cycle_result next_result();
        t_cycle_result res;
        logic [2:0]    lo;
        logic [2:0]    r;
        int            p;
        int            c;
        lo = sh_op[2:0];
        r  = sh_op[5:3];
        p  = sh_op[5:4];
        c  = sh_cyc;
        res = '0;
        if (!sh_halt) begin
            if (c + 1 >= op_cycles(sh_op)) begin
                res.addr = sh_pc;
            end else begin
                case (lo)
                    3'd0: begin
                        if (c <= 1) begin
                            res.addr = sh_pc;
                        end else begin
                            // LD [imm16],SP writes low byte then high byte
                            res.addr  = sh_tmp;
                            res.wr    = 1'b1;
                            res.wdata = (c == 2) ? sh_sp[7:0] : sh_sp[15:8];
                        end
                    end
                    3'd1: if (!sh_op[3]) res.addr = sh_pc;
                    3'd2: begin
                        res.addr = pair_rd(p > 2 ? 2 : p);
                        if (!sh_op[3]) begin
                            res.wr    = 1'b1;
                            res.wdata = sh_a;
                        end
                    end
                    3'd4, 3'd5, 3'd6: begin
                        if (lo == 3'd6 && c == 0) begin
                            res.addr = sh_pc;
                        end else if (r == SLOT_MEM) begin
                            res.addr = pair_rd(2);
                            if (c >= 1) begin
                                res.wr    = 1'b1;
                                res.wdata = sh_tmp[7:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        res.acc   = sh_a;
        res.flags = sh_f & 8'hF0;
        res.bc    = pair_rd(0);
        res.de    = pair_rd(1);
        res.hl    = pair_rd(2);
        res.sp    = sh_sp;
        res.pc    = sh_pc;
        res.stop  = sh_halt;
        return res;
    endfunction

    function bit fetch_due();
        return !sh_halt && sh_cyc + 1 >= op_cycles(sh_op);
    endfunction

    // Queue one memory reply together with the result it must produce.
    task queue_reply(input logic [7:0] d);
        t_mem_reply m;
        if (!sh_halt) exec_cycle(d);
        m.data = d;
        m.want = next_result();
        reply_q.push_back(m);
        total_items++;
    endtask

    function logic [7:0] random_opcode();
        logic [7:0] op;
        do op = 8'($urandom_range(0, 63)); while (!op_supported(op));
        return op;
    endfunction

    task report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] first_ops [$];
        int         k;
        bit         toggle;
        // Directed program: immediates of all ones and all zeros, SP store,
        // pointer loads and stores through DE and HL, ADD HL,SP, [HL] inc/dec/store,
        // A inc/dec and both rotates.
        first_ops = '{8'h31, 8'h01, 8'h08, 8'h39, 8'h22, 8'h3A, 8'h2A, 8'h12,
                      8'h1A, 8'h34, 8'h35, 8'h36, 8'h3C, 8'h3D, 8'h07, 8'h0F};
        k = 0;
        toggle = 1'b1;
        while (k < first_ops.size()) begin
            if (fetch_due()) begin
                queue_reply(first_ops[k]);
                k++;
            end else begin
                queue_reply(toggle ? 8'hFF : 8'h00);
                toggle = !toggle;
            end
        end
        // Random programs with random operands.
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_reply(fetch_due() ? random_opcode() : 8'($urandom_range(0, 255)));
        // Finish with an unsupported opcode, then a few stopped cycles.
        while (!fetch_due()) queue_reply(8'($urandom_range(0, 255)));
        queue_reply(8'hFF);
        repeat (4) queue_reply(8'($urandom_range(0, 255)));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < total_items) @(posedge i_clk);
        while (cycle_exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps; once, it waits for
    // the core to drain completely before going on.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_read_data <= 8'h00;
        end else begin
            if (i_valid && o_ready) begin
                cycle_exp_q.push_back(cur_reply.want);
                sent_cnt++;
            end
            if (!(i_valid && !o_ready)) begin
                if (sent_cnt == PAUSE_AT && !pause_done && cycle_exp_q.size() == 0)
                    pause_done = 1'b1;
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sent_cnt == PAUSE_AT && !pause_done) begin
                    i_valid <= 1'b0;
                end else if (reply_q.size() != 0) begin
                    cur_reply = reply_q.pop_front();
                    i_valid     <= 1'b1;
                    i_read_data <= cur_reply.data;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: ready in runs and stalls of random length; each result is
    // checked field by field against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cycle_result w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (cycle_exp_q.size() == 0) begin
                    report_mismatch("result with nothing expected", o_bus_address, '0);
                end else begin
                    w = cycle_exp_q.pop_front();
                    if (o_bus_address !== w.addr)
                        report_mismatch("bus_address", o_bus_address, w.addr);
                    if (o_bus_we !== w.wr)
                        report_mismatch("bus_we", 16'(o_bus_we), 16'(w.wr));
                    if (o_bus_wdata !== w.wdata)
                        report_mismatch("bus_wdata", 16'(o_bus_wdata), 16'(w.wdata));
                    if (o_acc_value !== w.acc)
                        report_mismatch("acc_value", 16'(o_acc_value), 16'(w.acc));
                    if (o_flag_value !== w.flags)
                        report_mismatch("flag_value", 16'(o_flag_value), 16'(w.flags));
                    if (o_pair_bc !== w.bc) report_mismatch("pair_bc", o_pair_bc, w.bc);
                    if (o_pair_de !== w.de) report_mismatch("pair_de", o_pair_de, w.de);
                    if (o_pair_hl !== w.hl) report_mismatch("pair_hl", o_pair_hl, w.hl);
                    if (o_stack_ptr !== w.sp) report_mismatch("stack_ptr", o_stack_ptr, w.sp);
                    if (o_prog_counter !== w.pc)
                        report_mismatch("prog_counter", o_prog_counter, w.pc);
                    if (o_stopped !== w.stop)
                        report_mismatch("stopped", 16'(o_stopped), 16'(w.stop));
                end
            end
            if (run_left > 0) begin
                run_left--;
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                run_left   = $urandom_range(0, 40);
                stall_left = $urandom_range(0, 6);
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end
endmodule
